/* rtl/euler_transform_matrix_top_assert.svh */
// assertion macros for the euler transform matrix rtl, used by etm_col
// needs clk_i in the scope of each use, and rst_ni as well for ETM_ASSERT
`ifndef EULER_TRANSFORM_MATRIX_TOP_ASSERT_SVH
`define EULER_TRANSFORM_MATRIX_TOP_ASSERT_SVH

// checked outside reset
`define ETM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("etm assertion failed");

// checked during reset as well
`define ETM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("etm assertion failed");

`endif

/* rtl/etm_pkg.sv */
`timescale 1ns / 1ps
// shared types, constants and arithmetic helpers of the euler transform matrix
// no dependencies
package etm_pkg;

  localparam int unsigned CHAIN_LEN = 25;
  localparam int unsigned MAX_ITER  = 24;

  localparam logic signed [32:0] ANG_PI      = 33'sd843314857;
  localparam logic signed [32:0] ANG_HALF_PI = 33'sd421657428;
  localparam logic signed [32:0] ANG_TWO_PI  = 33'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [24:0]        NUM_BASE    = 25'h1000000;

  localparam logic [2:0] COL_TRANS = 3'd3;
  localparam logic [2:0] NORM_BASE = 3'd4;
  localparam logic [2:0] LAST_COL  = 3'd6;
  localparam logic       SEL_MODEL  = 1'b0;
  localparam logic       SEL_NORMAL = 1'b1;

  localparam logic [23:0][31:0] ATAN_Q28 = {
    32'd32,       32'd64,       32'd128,      32'd256,
    32'd512,      32'd1024,     32'd2048,     32'd4096,
    32'd8192,     32'd16384,    32'd32768,    32'd65536,
    32'd131072,   32'd262144,   32'd524287,   32'd1048571,
    32'd2097109,  32'd4193963,  32'd8385879,  32'd16755422,
    32'd33381290, 32'd65760959, 32'd124459457, 32'd210828714};

  typedef struct packed {
    logic [2:0][33:0] x;
    logic [2:0][33:0] y;
    logic [2:0][31:0] z;
    logic [2:0]       neg;
    logic [2:0][15:0] sc;
    logic [2:0][15:0] m;
    logic [2:0][16:0] rem;
    logic [2:0][24:0] quo;
  } etm_cell_t;

  typedef struct packed {
    logic [2:0][2:0][33:0] r;
    logic [2:0][15:0]      sc;
    logic [2:0][24:0]      invm;
    logic [2:0]            zf;
  } etm_rot_t;

  function automatic logic [31:0] etm_atan(input int unsigned i);
    logic [31:0] v;
    v = '0;
    if (i < MAX_ITER) v = ATAN_Q28[i];
    return v;
  endfunction

  // q.30 times q.30, rounded half away from zero
  function automatic logic signed [33:0] etm_mulr30(input logic signed [33:0] a,
                                                    input logic signed [33:0] b);
    logic [33:0] ua;
    logic [33:0] ub;
    logic [67:0] p;
    logic [67:0] rr;
    logic signed [33:0] res;
    ua  = a[33] ? 34'(-a) : 34'(a);
    ub  = b[33] ? 34'(-b) : 34'(b);
    p   = 68'(ua) * 68'(ub);
    rr  = (p + (68'd1 << 29)) >> 30;
    res = signed'(rr[33:0]);
    return (a[33] ^ b[33]) ? -res : res;
  endfunction

endpackage

/* rtl/etm_cell.sv */
`timescale 1ns / 1ps
// one cell of the chain: per lane one reciprocal quotient bit and, for IDX
// below min(TRIG_STAGES, MAX_ITER), one cordic iteration; uses etm_pkg
module etm_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned TRIG_STAGES = 16,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  etm_pkg::etm_cell_t                data_i,
  input  logic [2:0][VALUE_BITS-1:0]        shift_i,
  output logic                              valid_o,
  output etm_pkg::etm_cell_t                data_o,
  output logic [2:0][VALUE_BITS-1:0]        shift_o
);
  import etm_pkg::*;

  localparam int unsigned NITER   = (TRIG_STAGES < MAX_ITER) ? TRIG_STAGES : MAX_ITER;
  localparam int unsigned DIV_BIT = CHAIN_LEN - 1 - IDX;
  localparam logic signed [31:0] ATAN = signed'(etm_atan(IDX));

  etm_cell_t data_d, data_q;
  logic [2:0][VALUE_BITS-1:0] shift_q;
  logic valid_q;

  always_comb begin
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [31:0] zs;
    logic [24:0] num;
    logic [16:0] rs;
    logic qb;
    data_d = data_i;
    for (int l = 0; l < 3; l++) begin
      xs = signed'(data_i.x[l]);
      ys = signed'(data_i.y[l]);
      zs = signed'(data_i.z[l]);
      if (IDX < NITER) begin
        if (!zs[31]) begin
          data_d.x[l] = xs - (ys >>> IDX);
          data_d.y[l] = ys + (xs >>> IDX);
          data_d.z[l] = zs - ATAN;
        end else begin
          data_d.x[l] = xs + (ys >>> IDX);
          data_d.y[l] = ys - (xs >>> IDX);
          data_d.z[l] = zs + ATAN;
        end
      end
      num = NUM_BASE + 25'(data_i.m[l] >> 1);
      rs  = {data_i.rem[l][15:0], num[DIV_BIT]};
      if (rs >= 17'(data_i.m[l])) begin
        data_d.rem[l] = rs - 17'(data_i.m[l]);
        qb = 1'b1;
      end else begin
        data_d.rem[l] = rs;
        qb = 1'b0;
      end
      data_d.quo[l] = {data_i.quo[l][23:0], qb};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q  <= data_d;
      shift_q <= shift_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign shift_o = shift_q;

endmodule

/* rtl/etm_rot.sv */
`timescale 1ns / 1ps
// rotation matrix from sine and cosine, two product stages, and reciprocals
// uses etm_pkg
module etm_rot #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  etm_pkg::etm_cell_t         data_i,
  input  logic [2:0][VALUE_BITS-1:0] shift_i,
  output logic                       valid_o,
  output etm_pkg::etm_rot_t          rot_o,
  output logic [2:0][VALUE_BITS-1:0] shift_o
);
  import etm_pkg::*;

  localparam logic [48:0] MXW = (49'd1 << (VALUE_BITS - 1)) - 49'd1;

  logic signed [33:0] c1, s1, c2, s2, c3, s3;
  logic signed [33:0] s1s2_d, c1s2_d, c1c3_d, c2s3_d, c3s1_d;
  logic signed [33:0] c1s3_d, c2c3_d, s1s3_d, c2s1_d, c1c2_d;
  logic signed [33:0] s1s2_q, c1s2_q, c1c3_q, c2s3_q, c3s1_q;
  logic signed [33:0] c1s3_q, c2c3_q, s1s3_q, c2s1_q, c1c2_q;
  logic signed [33:0] s2_q, s3_q, c3_q;
  logic [2:0][15:0] sc_q;
  logic [2:0][24:0] invm_d, invm_q;
  logic [2:0] zf_d, zf_q;
  logic [2:0][VALUE_BITS-1:0] shift_a_q, shift_b_q;
  logic valid_a_q, valid_b_q;
  etm_rot_t rot_d, rot_q;

  always_comb begin
    c2 = data_i.neg[0] ? -signed'(data_i.x[0]) : signed'(data_i.x[0]);
    s2 = data_i.neg[0] ? -signed'(data_i.y[0]) : signed'(data_i.y[0]);
    c1 = data_i.neg[1] ? -signed'(data_i.x[1]) : signed'(data_i.x[1]);
    s1 = data_i.neg[1] ? -signed'(data_i.y[1]) : signed'(data_i.y[1]);
    c3 = data_i.neg[2] ? -signed'(data_i.x[2]) : signed'(data_i.x[2]);
    s3 = data_i.neg[2] ? -signed'(data_i.y[2]) : signed'(data_i.y[2]);
    s1s2_d = etm_mulr30(s1, s2);
    c1s2_d = etm_mulr30(c1, s2);
    c1c3_d = etm_mulr30(c1, c3);
    c2s3_d = etm_mulr30(c2, s3);
    c3s1_d = etm_mulr30(c3, s1);
    c1s3_d = etm_mulr30(c1, s3);
    c2c3_d = etm_mulr30(c2, c3);
    s1s3_d = etm_mulr30(s1, s3);
    c2s1_d = etm_mulr30(c2, s1);
    c1c2_d = etm_mulr30(c1, c2);
    for (int l = 0; l < 3; l++) begin
      zf_d[l] = (data_i.m[l] == 16'd0);
      if (zf_d[l]) begin
        invm_d[l] = '0;
      end else if (49'(data_i.quo[l]) > MXW) begin
        invm_d[l] = 25'(MXW);
      end else begin
        invm_d[l] = data_i.quo[l];
      end
    end
  end

  always_comb begin
    rot_d.r[0][0] = c1c3_q + etm_mulr30(s1s2_q, s3_q);
    rot_d.r[0][1] = c2s3_q;
    rot_d.r[0][2] = etm_mulr30(c1s2_q, s3_q) - c3s1_q;
    rot_d.r[1][0] = etm_mulr30(s1s2_q, c3_q) - c1s3_q;
    rot_d.r[1][1] = c2c3_q;
    rot_d.r[1][2] = etm_mulr30(c1c3_q, s2_q) + s1s3_q;
    rot_d.r[2][0] = c2s1_q;
    rot_d.r[2][1] = -s2_q;
    rot_d.r[2][2] = c1c2_q;
    rot_d.sc      = sc_q;
    rot_d.invm    = invm_q;
    rot_d.zf      = zf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en_i) begin
      valid_a_q <= valid_i;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1s2_q <= s1s2_d; c1s2_q <= c1s2_d; c1c3_q <= c1c3_d;
      c2s3_q <= c2s3_d; c3s1_q <= c3s1_d; c1s3_q <= c1s3_d;
      c2c3_q <= c2c3_d; s1s3_q <= s1s3_d; c2s1_q <= c2s1_d;
      c1c2_q <= c1c2_d;
      s2_q <= s2; s3_q <= s3; c3_q <= c3;
      sc_q <= data_i.sc;
      invm_q <= invm_d;
      zf_q <= zf_d;
      shift_a_q <= shift_i;
      rot_q <= rot_d;
      shift_b_q <= shift_a_q;
    end
  end

  assign valid_o = valid_b_q;
  assign rot_o   = rot_q;
  assign shift_o = shift_b_q;

endmodule

/* rtl/etm_col.sv */
`timescale 1ns / 1ps
// column sequencer: holds one item and sends its seven columns through the
// output register; uses etm_pkg and the assertion macro header
`include "euler_transform_matrix_top_assert.svh"
module etm_col #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rot_valid_i,
  output logic                         rot_ready_o,
  input  etm_pkg::etm_rot_t            rot_i,
  input  logic [2:0][VALUE_BITS-1:0]   shift_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         matrix_select_o,
  output logic [1:0]                   column_number_o,
  output logic signed [VALUE_BITS-1:0] element_0_o,
  output logic signed [VALUE_BITS-1:0] element_1_o,
  output logic signed [VALUE_BITS-1:0] element_2_o,
  output logic signed [VALUE_BITS-1:0] element_3_o,
  output logic                         zero_scale_flag_o,
  output logic                         last_column_o
);
  import etm_pkg::*;

  localparam int unsigned PW = VALUE_BITS + 35;
  localparam logic [PW-1:0] MX = (PW'(1) << (VALUE_BITS - 1)) - PW'(1);
  localparam logic [PW-1:0] ONE_Q16 = PW'(65536);

  etm_rot_t buf_q;
  logic [2:0][VALUE_BITS-1:0] shift_q;
  logic buf_valid_q;
  logic [2:0] cnt_q, cnt_d;
  logic out_valid_q;
  logic sel_q;
  logic [1:0] col_q;
  logic [2:0][VALUE_BITS-1:0] e_q, e_d;
  logic [VALUE_BITS-1:0] e3_q;
  logic flag_q, last_q;

  logic emit, done, load, is_norm, is_trans;
  logic [1:0] k;
  logic [24:0] bm;
  logic bneg, zer;

  function automatic logic [VALUE_BITS-1:0] elem(input logic signed [33:0] r,
                                                 input logic [24:0] b,
                                                 input logic bn,
                                                 input logic z,
                                                 input logic norm);
    logic [33:0] ua;
    logic [58:0] pm;
    logic [PW-1:0] p;
    logic [PW-1:0] rr;
    logic [PW-1:0] v;
    logic neg;
    ua  = r[33] ? 34'(-r) : 34'(r);
    pm  = 59'(ua) * 59'(b);
    p   = z ? ((PW'(ua) << (VALUE_BITS - 1)) - PW'(ua)) : PW'(pm);
    rr  = norm ? ((p + (PW'(1) << 29)) >> 30) : ((p + (PW'(1) << 21)) >> 22);
    neg = r[33] ^ bn;
    if (!neg) begin
      v = (rr > MX) ? MX : rr;
    end else begin
      v = (rr > MX + PW'(1)) ? (MX + PW'(1)) : rr;
      v = -v;
    end
    return v[VALUE_BITS-1:0];
  endfunction

  always_comb begin
    is_norm  = (cnt_q >= NORM_BASE);
    is_trans = (cnt_q == COL_TRANS);
    if (is_norm) begin
      k = 2'(cnt_q - NORM_BASE);
    end else if (is_trans) begin
      k = 2'd0;
    end else begin
      k = cnt_q[1:0];
    end
    bneg = buf_q.sc[k][15];
    zer  = is_norm && buf_q.zf[k];
    if (is_norm) begin
      bm = buf_q.invm[k];
    end else begin
      bm = 25'(bneg ? 16'(-buf_q.sc[k]) : buf_q.sc[k]);
    end
    for (int j = 0; j < 3; j++) begin
      e_d[j] = is_trans ? shift_q[j] : elem(signed'(buf_q.r[k][j]), bm, bneg, zer, is_norm);
    end
  end

  assign emit        = buf_valid_q && (!out_valid_q || out_ready_i);
  assign done        = emit && (cnt_q == LAST_COL);
  assign rot_ready_o = !buf_valid_q || done;
  assign load        = rot_valid_i && rot_ready_o;
  assign cnt_d       = done ? 3'd0 : 3'(cnt_q + 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      cnt_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        buf_valid_q <= 1'b1;
      end else if (done) begin
        buf_valid_q <= 1'b0;
      end
      if (emit) begin
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q   <= rot_i;
      shift_q <= shift_i;
    end
    if (emit) begin
      sel_q  <= is_norm ? SEL_NORMAL : SEL_MODEL;
      col_q  <= is_trans ? 2'd3 : k;
      e_q    <= e_d;
      e3_q   <= is_trans ? ONE_Q16[VALUE_BITS-1:0] : '0;
      flag_q <= zer;
      last_q <= (cnt_q == LAST_COL);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign matrix_select_o   = sel_q;
  assign column_number_o   = col_q;
  assign element_0_o       = e_q[0];
  assign element_1_o       = e_q[1];
  assign element_2_o       = e_q[2];
  assign element_3_o       = e3_q;
  assign zero_scale_flag_o = flag_q;
  assign last_column_o     = last_q;

  `ETM_ASSERT(a_last_is_normal_col2, out_valid_o && last_column_o |-> matrix_select_o == SEL_NORMAL && column_number_o == 2'd2)
  `ETM_ASSERT(a_flag_on_normal, out_valid_o && zero_scale_flag_o |-> matrix_select_o == SEL_NORMAL)
  `ETM_ASSERT(a_e3_only_trans, out_valid_o && !(matrix_select_o == SEL_MODEL && column_number_o == 2'd3) |-> element_3_o == '0)
  `ETM_ASSERT_ALWAYS(a_load_when_free, load |-> !buf_valid_q || cnt_q == LAST_COL)

endmodule

/* rtl/euler_transform_matrix_top.sv */
`timescale 1ns / 1ps
// top level of the euler transform matrix: angle fold, cell chain, rotation
// products and column sequencer; uses etm_pkg, etm_cell, etm_rot, etm_col
//
// channel | handshake              | payload
// in      | in_valid_i / in_ready_o | angles, scales, shifts (one word per item)
// out     | out_valid_o / out_ready_i | one matrix column per word, seven per item
//
// one item enters per cycle while the column sequencer has room; sustained
// throughput is bounded by the seven columns each item takes on the out channel
// on its way to the first column an item passes 25 chain cells, 2 product
// stages, the sequencer buffer and the output register
// reset clears only valid flags and counters; a stall on out freezes the chain
module euler_transform_matrix_top #(
  parameter int unsigned ANGLE_BITS  = 16,
  parameter int unsigned VALUE_BITS  = 32,
  parameter int unsigned TRIG_STAGES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [ANGLE_BITS-1:0] angle_x_i,
  input  logic signed [ANGLE_BITS-1:0] angle_y_i,
  input  logic signed [ANGLE_BITS-1:0] angle_z_i,
  input  logic signed [15:0]           scale_x_i,
  input  logic signed [15:0]           scale_y_i,
  input  logic signed [15:0]           scale_z_i,
  input  logic signed [VALUE_BITS-1:0] shift_x_i,
  input  logic signed [VALUE_BITS-1:0] shift_y_i,
  input  logic signed [VALUE_BITS-1:0] shift_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         matrix_select_o,
  output logic [1:0]                   column_number_o,
  output logic signed [VALUE_BITS-1:0] element_0_o,
  output logic signed [VALUE_BITS-1:0] element_1_o,
  output logic signed [VALUE_BITS-1:0] element_2_o,
  output logic signed [VALUE_BITS-1:0] element_3_o,
  output logic                         zero_scale_flag_o,
  output logic                         last_column_o
);
  import etm_pkg::*;

  etm_cell_t                  chain [CHAIN_LEN+1];
  logic                       chain_valid [CHAIN_LEN+1];
  logic [2:0][VALUE_BITS-1:0] chain_shift [CHAIN_LEN+1];

  logic [2:0][ANGLE_BITS-1:0] ang;
  logic [2:0][15:0]           scl;
  logic adv, rot_valid, col_ready;
  etm_rot_t rot;
  logic [2:0][VALUE_BITS-1:0] rot_shift;

  assign ang = {angle_z_i, angle_y_i, angle_x_i};
  assign scl = {scale_z_i, scale_y_i, scale_x_i};

  // fold to +-pi/2 and seed cordic and divider lanes
  always_comb begin
    logic signed [32:0] zw;
    chain[0] = '0;
    for (int l = 0; l < 3; l++) begin
      zw = 33'(signed'(ang[l])) <<< (32 - ANGLE_BITS);
      if (zw > ANG_PI) begin
        zw = zw - ANG_TWO_PI;
      end else if (zw < -ANG_PI) begin
        zw = zw + ANG_TWO_PI;
      end
      chain[0].neg[l] = 1'b0;
      if (zw > ANG_HALF_PI) begin
        zw = zw - ANG_PI;
        chain[0].neg[l] = 1'b1;
      end else if (zw < -ANG_HALF_PI) begin
        zw = zw + ANG_PI;
        chain[0].neg[l] = 1'b1;
      end
      chain[0].z[l] = zw[31:0];
      chain[0].x[l] = CORDIC_GAIN;
      chain[0].y[l] = '0;
      chain[0].sc[l] = scl[l];
      chain[0].m[l] = scl[l][15] ? 16'(-scl[l]) : scl[l];
      chain[0].rem[l] = '0;
      chain[0].quo[l] = '0;
    end
  end

  assign chain_valid[0] = in_valid_i;
  assign chain_shift[0] = {shift_z_i, shift_y_i, shift_x_i};

  assign adv        = !rot_valid || col_ready;
  assign in_ready_o = adv;

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
    etm_cell #(
      .IDX        (i),
      .TRIG_STAGES(TRIG_STAGES),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .valid_i(chain_valid[i]),
      .data_i (chain[i]),
      .shift_i(chain_shift[i]),
      .valid_o(chain_valid[i+1]),
      .data_o (chain[i+1]),
      .shift_o(chain_shift[i+1])
    );
  end

  etm_rot #(
    .VALUE_BITS(VALUE_BITS)
  ) u_rot (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .valid_i(chain_valid[CHAIN_LEN]),
    .data_i (chain[CHAIN_LEN]),
    .shift_i(chain_shift[CHAIN_LEN]),
    .valid_o(rot_valid),
    .rot_o  (rot),
    .shift_o(rot_shift)
  );

  etm_col #(
    .VALUE_BITS(VALUE_BITS)
  ) u_col (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rot_valid_i      (rot_valid),
    .rot_ready_o      (col_ready),
    .rot_i            (rot),
    .shift_i          (rot_shift),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .matrix_select_o  (matrix_select_o),
    .column_number_o  (column_number_o),
    .element_0_o      (element_0_o),
    .element_1_o      (element_1_o),
    .element_2_o      (element_2_o),
    .element_3_o      (element_3_o),
    .zero_scale_flag_o(zero_scale_flag_o),
    .last_column_o    (last_column_o)
  );

endmodule
